// ===== hw/rtl/mksm_pkg.sv =====
package mksm_pkg;

  localparam int DEF_MAX_ENTRIES  = 64;
  localparam int DEF_MAX_SEQUENCE = 4;

  localparam logic [15:0] DEF_TIMEOUT = 16'd500;

  localparam logic [4:0] HINT_CTRL = 5'h06;
  localparam logic [4:0] HINT_ALT  = 5'h18;

  // input transaction kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_NONE    = 3'd0;
  localparam logic [2:0] STAT_PENDING = 3'd1;
  localparam logic [2:0] STAT_ACTION  = 3'd2;
  localparam logic [2:0] STAT_FAIL    = 3'd3;
  localparam logic [2:0] STAT_REJECT  = 3'd4;

  // config register indexes
  localparam logic [1:0] CFG_MODE_3270 = 2'd0;
  localparam logic [1:0] CFG_MODE_NVT  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  // scan kinds carried along the cell chain
  typedef enum logic [1:0] {
    OP_FIRST,   // first code of a fresh match, shortest wins
    OP_ADV,     // first binding that continues the current prefix
    OP_LONG,    // shortest longer binding sharing a completed prefix
    OP_OFF      // override check for one target entry
  } mksm_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_CHECK,
    S_ADV,
    S_LONG,
    S_RECOMP,
    S_EMIT
  } mksm_state_t;

  typedef struct packed {
    logic     valid;
    mksm_op_t op;
    logic     have;
    logic     done;
    logic     shadow;
  } mksm_ctl_t;

  typedef struct packed {
    logic [23:0] q_code;
    logic [4:0]  q_st;
    logic        mode_3270;
    logic        mode_nvt;
    logic        code_we;
    logic        commit;
    logic        off_we;
    logic        off_val;
    logic [23:0] wr_code;
    logic [4:0]  wr_hint;
    logic [1:0]  wr_mode;
    logic [15:0] wr_action;
  } mksm_bcast_t;

  // both ctrl (or both alt) bits in the hint: either one pressed counts as both
  function automatic logic hint_ok(input logic [4:0] h, input logic [4:0] st);
    logic [4:0] s;
    s = st;
    if ((h & HINT_CTRL) == HINT_CTRL && (st & HINT_CTRL) != 5'd0) s = s | HINT_CTRL;
    if ((h & HINT_ALT) == HINT_ALT && (st & HINT_ALT) != 5'd0) s = s | HINT_ALT;
    return (h == 5'd0) || ((h & s) == h);
  endfunction

endpackage

// ===== hw/rtl/mksm_cell.sv =====
module mksm_cell
  import mksm_pkg::*;
#(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int MAX_SEQUENCE = DEF_MAX_SEQUENCE,
  parameter int IDX          = 0,
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int LW = $clog2(MAX_SEQUENCE + 1),
  localparam int PW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mksm_bcast_t                    bc,
  input  logic [CW-1:0]                  count,
  input  logic [LW-1:0]                  c,
  input  logic [MAX_SEQUENCE-1:0][23:0]  ref_codes,
  input  logic [MAX_SEQUENCE-1:0][4:0]   ref_hints,
  input  logic [IW-1:0]                  wr_entry,
  input  logic [PW-1:0]                  wr_pos,
  input  logic [LW-1:0]                  wr_len,
  input  mksm_ctl_t                      in_ctl,
  input  logic [IW-1:0]                  in_excl,
  input  logic [IW-1:0]                  in_bidx,
  input  logic [MAX_SEQUENCE-1:0][23:0]  in_bcodes,
  input  logic [MAX_SEQUENCE-1:0][4:0]   in_bhints,
  input  logic [LW-1:0]                  in_blen,
  input  logic [15:0]                    in_bact,
  output mksm_ctl_t                      out_ctl,
  output logic [IW-1:0]                  out_excl,
  output logic [IW-1:0]                  out_bidx,
  output logic [MAX_SEQUENCE-1:0][23:0]  out_bcodes,
  output logic [MAX_SEQUENCE-1:0][4:0]   out_bhints,
  output logic [LW-1:0]                  out_blen,
  output logic [15:0]                    out_bact
);

  logic [MAX_SEQUENCE-1:0][23:0] codes;
  logic [MAX_SEQUENCE-1:0][4:0]  hints;
  logic [LW-1:0]                 len;
  logic [1:0]                    mode;
  logic [15:0]                   action;
  logic                          off;

  logic [23:0] code_c;
  logic [4:0]  hint_c;
  logic        act, mode_off, c_ok, pre_ref, pre_best, take, mine;
  mksm_ctl_t   ctl_next;

  // codes of a equal those of b below n; nonzero hints of a equal b's
  function automatic logic prefix_eq(
    input logic [MAX_SEQUENCE-1:0][23:0] ac,
    input logic [MAX_SEQUENCE-1:0][4:0]  ah,
    input logic [MAX_SEQUENCE-1:0][23:0] bcd,
    input logic [MAX_SEQUENCE-1:0][4:0]  bh,
    input logic [LW-1:0]                 n
  );
    logic ok;
    ok = 1'b1;
    for (int p = 0; p < MAX_SEQUENCE; p++) begin
      if (LW'(p) < n) begin
        if (ac[p] != bcd[p]) ok = 1'b0;
        if (ah[p] != 5'd0 && ah[p] != bh[p]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign mine = (wr_entry == IW'(IDX));

  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_SEQUENCE; p++) begin
      if (bc.code_we && mine && wr_pos == PW'(p)) begin
        codes[p] <= bc.wr_code;
        hints[p] <= bc.wr_hint;
      end
    end
    if (bc.commit && mine) begin
      len    <= wr_len;
      mode   <= bc.wr_mode;
      action <= bc.wr_action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off <= 1'b0;
    end else if (bc.off_we && mine) begin
      off <= bc.off_val;
    end
  end

  always_comb begin
    code_c = '0;
    hint_c = '0;
    for (int p = 0; p < MAX_SEQUENCE; p++) begin
      if (LW'(p) == c) begin
        code_c = codes[p];
        hint_c = hints[p];
      end
    end
  end

  assign mode_off = (mode[0] & ~bc.mode_3270) | (mode[1] & ~bc.mode_nvt);
  assign act      = (CW'(IDX) < count) && !off;
  assign c_ok     = (c < LW'(MAX_SEQUENCE));
  assign pre_ref  = prefix_eq(codes, hints, ref_codes, ref_hints, c);
  assign pre_best = prefix_eq(in_bcodes, in_bhints, codes, hints, in_blen);

  always_comb begin
    ctl_next = in_ctl;
    take     = 1'b0;
    case (in_ctl.op)
      OP_FIRST: begin
        if (in_ctl.valid && act && !in_ctl.done && codes[0] == bc.q_code &&
            hint_ok(hints[0], bc.q_st)) begin
          if (len == LW'(1)) begin
            take          = 1'b1;
            ctl_next.done = 1'b1;
          end else if (!in_ctl.have || len < in_blen) begin
            take = 1'b1;
          end
        end
      end
      OP_ADV: begin
        if (in_ctl.valid && act && in_excl != IW'(IDX) && !in_ctl.have && len > c &&
            c_ok && pre_ref && code_c == bc.q_code && hint_ok(hint_c, bc.q_st)) begin
          take = 1'b1;
        end
      end
      OP_LONG: begin
        if (in_ctl.valid && act && in_excl != IW'(IDX) && !in_ctl.done && len > c &&
            pre_ref) begin
          if (len - c == LW'(1)) begin
            take          = 1'b1;
            ctl_next.done = 1'b1;
          end else if (!in_ctl.have || len < in_blen) begin
            take = 1'b1;
          end
        end
      end
      OP_OFF: begin
        if (in_ctl.valid) begin
          if (in_excl == IW'(IDX)) begin
            take            = 1'b1;
            ctl_next.shadow = mode_off;
          end else if (IW'(IDX) > in_excl && CW'(IDX) < count && !mode_off &&
                       len == in_blen && pre_best) begin
            ctl_next.shadow = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (take) ctl_next.have = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    out_excl <= in_excl;
    if (take) begin
      out_bidx   <= IW'(IDX);
      out_bcodes <= codes;
      out_bhints <= hints;
      out_blen   <= len;
      out_bact   <= action;
    end else begin
      out_bidx   <= in_bidx;
      out_bcodes <= in_bcodes;
      out_bhints <= in_bhints;
      out_blen   <= in_blen;
      out_bact   <= in_bact;
    end
  end

endmodule

// ===== hw/rtl/multi_key_sequence_matcher.sv =====
// Key-sequence binding matcher.
// Input stream (s_*): one transaction per command. s_tuser is the kind: load one
// binding code, key event, timer tick, clear table. s_tlast marks the final code of a
// binding being loaded. Output stream (m_*): at most one result per input transaction
// (status in m_tuser; action id and compose flag in m_tdata).
// Config port: cfg_we/cfg_index/cfg_data. The user must write it only while the block is
// idle; the block itself does not enforce this. The table lives in a row of MAX_ENTRIES
// cells, one binding per cell. A search record enters cell 0 and moves one cell per clock.
// A key event takes up to two table scans. Committing a binding or writing a mode register
// starts an override pass, with one record per entry back to back; no input is taken
// meanwhile. One item is in flight at a time. Results go through an output register, so
// the next input is taken while a result still waits for m_tready; a later result then
// waits. Reset empties the table, drops any pending match or timeout and sets timeout
// to 500.
module multi_key_sequence_matcher
  import mksm_pkg::*;
#(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int MAX_SEQUENCE = DEF_MAX_SEQUENCE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key_code[23:0], modifier_bits[28:24], mode_limit[30:29],
                                 // action_in[46:31], zero [47]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        s_tlast,   // last_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // action_out[15:0], compose_on[16], zero [23:17]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = $clog2(MAX_SEQUENCE + 1);
  localparam int PW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
  localparam int N  = MAX_ENTRIES;

  // input field views
  logic [23:0] in_code;
  logic [4:0]  in_mods;
  logic [1:0]  in_limit;
  logic [15:0] in_action;
  logic [1:0]  kind;

  assign in_code   = s_tdata[23:0];
  assign in_mods   = s_tdata[28:24];
  assign in_limit  = s_tdata[30:29];
  assign in_action = s_tdata[46:31];
  assign kind      = s_tuser;

  // config registers
  logic        mode_3270, mode_nvt;
  logic [15:0] timeout_ticks;

  // control state
  mksm_state_t state, state_next;
  logic [CW-1:0] entry_count;
  logic [LW-1:0] load_length;
  logic          load_discard;
  logic          match_valid;
  logic [LW-1:0] consumed;
  logic          timeout_armed;
  logic [15:0]   timeout_count;
  logic [15:0]   timeout_action;
  logic          recomp_req;
  logic          launch;
  logic [CW-1:0] inj_cnt, col_cnt;

  // current partial match (copy of its table entry)
  logic [IW-1:0]                 cur_idx;
  logic [MAX_SEQUENCE-1:0][23:0] cur_codes;
  logic [MAX_SEQUENCE-1:0][4:0]  cur_hints;
  logic [LW-1:0]                 cur_len;
  logic [15:0]                   cur_action;

  // latched key event
  logic [23:0] q_code;
  logic [4:0]  q_st;

  // result waiting for the output register
  logic [2:0]  pend_status;
  logic [15:0] pend_action;
  logic        pend_compose;

  logic [2:0]  out_status;
  logic [15:0] out_action;
  logic        out_compose;

  // cell chain
  mksm_ctl_t                     ch_ctl    [N+1];
  logic [IW-1:0]                 ch_excl   [N+1];
  logic [IW-1:0]                 ch_bidx   [N+1];
  logic [MAX_SEQUENCE-1:0][23:0] ch_bcodes [N+1];
  logic [MAX_SEQUENCE-1:0][4:0]  ch_bhints [N+1];
  logic [LW-1:0]                 ch_blen   [N+1];
  logic [15:0]                   ch_bact   [N+1];

  mksm_bcast_t   bc;
  logic [IW-1:0] wr_entry;
  logic [PW-1:0] wr_pos;
  logic [LW-1:0] wr_len;

  logic accept, mode_wr, load_ok, code_we, commit, reject, tick_fire;
  logic res_valid, res_have;
  logic [23:0] cur_code_c;
  logic [4:0]  cur_hint_c;
  logic chk_hit, chk_done, adv_done;
  logic [LW-1:0] chk_next;
  logic [15:0] ticks_eff;
  logic out_free;

  function automatic logic [LW-1:0] chk_len_of(input logic [LW-1:0] l);
    return LW'(l + LW'(1));
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign mode_wr  = cfg_we && (cfg_index == CFG_MODE_3270 || cfg_index == CFG_MODE_NVT);
  assign load_ok  = (entry_count < CW'(N)) && (load_length < LW'(MAX_SEQUENCE));
  assign code_we  = accept && kind == KIND_LOAD && !load_discard && load_ok;
  assign commit   = code_we && s_tlast;
  // codes of a dropped binding are refused too
  assign reject   = load_discard || !load_ok;
  assign tick_fire = timeout_armed && timeout_count <= 16'd1;
  assign res_valid = ch_ctl[N].valid;
  assign res_have  = ch_ctl[N].have;
  assign ticks_eff = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign out_free  = !m_tvalid || m_tready;

  // direct check of the current binding at the consumed position
  always_comb begin
    cur_code_c = '0;
    cur_hint_c = '0;
    for (int p = 0; p < MAX_SEQUENCE; p++) begin
      if (LW'(p) == consumed) begin
        cur_code_c = cur_codes[p];
        cur_hint_c = cur_hints[p];
      end
    end
  end

  assign chk_hit  = (consumed < LW'(MAX_SEQUENCE)) && cur_code_c == q_code &&
                    hint_ok(cur_hint_c, q_st);
  assign chk_next = LW'(consumed + LW'(1));
  assign chk_done = (chk_next >= cur_len);
  assign adv_done = (ch_blen[N] - consumed == LW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (recomp_req) begin
          state_next = S_RECOMP;
        end else if (accept) begin
          case (kind)
            KIND_LOAD:  if (reject) state_next = S_EMIT;
            KIND_KEY:   state_next = match_valid ? S_CHECK : S_FIRST;
            KIND_TICK:  if (tick_fire) state_next = S_EMIT;
            default:    ;
          endcase
        end
      end
      S_FIRST:  if (res_valid) state_next = res_have ? S_CHECK : S_EMIT;
      S_CHECK:  state_next = chk_hit ? (chk_done ? S_LONG : S_EMIT) : S_ADV;
      S_ADV:    if (res_valid) state_next = (res_have && adv_done) ? S_LONG : S_EMIT;
      S_LONG:   if (res_valid) state_next = S_EMIT;
      S_RECOMP: if (res_valid && col_cnt == CW'(N - 1)) state_next = S_IDLE;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs toward the chain and the input side
  always_comb begin
    s_tready = (state == S_IDLE) && !recomp_req && !mode_wr;

    ch_ctl[0]    = '0;
    ch_ctl[0].op = OP_FIRST;
    ch_excl[0]   = cur_idx;
    unique case (state)
      S_FIRST: begin
        ch_ctl[0].valid = launch;
        ch_ctl[0].op    = OP_FIRST;
      end
      S_ADV: begin
        ch_ctl[0].valid = launch;
        ch_ctl[0].op    = OP_ADV;
      end
      S_LONG: begin
        ch_ctl[0].valid = launch;
        ch_ctl[0].op    = OP_LONG;
      end
      S_RECOMP: begin
        ch_ctl[0].valid = (inj_cnt < CW'(N));
        ch_ctl[0].op    = OP_OFF;
        ch_excl[0]      = inj_cnt[IW-1:0];
      end
      default: ;
    endcase
    ch_bidx[0]   = '0;
    ch_bcodes[0] = '0;
    ch_bhints[0] = '0;
    ch_blen[0]   = '0;
    ch_bact[0]   = '0;

    bc.q_code    = q_code;
    bc.q_st      = q_st;
    bc.mode_3270 = mode_3270;
    bc.mode_nvt  = mode_nvt;
    bc.code_we   = code_we;
    bc.commit    = commit;
    bc.off_we    = (state == S_RECOMP) && res_valid;
    bc.off_val   = ch_ctl[N].shadow;
    bc.wr_code   = in_code;
    bc.wr_hint   = in_mods;
    bc.wr_mode   = in_limit;
    bc.wr_action = in_action;

    wr_entry = (state == S_RECOMP) ? ch_excl[N] : entry_count[IW-1:0];
    wr_pos   = load_length[PW-1:0];
    wr_len   = chk_len_of(load_length);
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      mksm_cell #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SEQUENCE(MAX_SEQUENCE),
        .IDX         (gi)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .bc        (bc),
        .count     (entry_count),
        .c         (consumed),
        .ref_codes (cur_codes),
        .ref_hints (cur_hints),
        .wr_entry  (wr_entry),
        .wr_pos    (wr_pos),
        .wr_len    (wr_len),
        .in_ctl    (ch_ctl[gi]),
        .in_excl   (ch_excl[gi]),
        .in_bidx   (ch_bidx[gi]),
        .in_bcodes (ch_bcodes[gi]),
        .in_bhints (ch_bhints[gi]),
        .in_blen   (ch_blen[gi]),
        .in_bact   (ch_bact[gi]),
        .out_ctl   (ch_ctl[gi+1]),
        .out_excl  (ch_excl[gi+1]),
        .out_bidx  (ch_bidx[gi+1]),
        .out_bcodes(ch_bcodes[gi+1]),
        .out_bhints(ch_bhints[gi+1]),
        .out_blen  (ch_blen[gi+1]),
        .out_bact  (ch_bact[gi+1])
      );
    end
  endgenerate

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode_3270     <= 1'b0;
      mode_nvt      <= 1'b0;
      timeout_ticks <= DEF_TIMEOUT;
      entry_count   <= '0;
      load_length   <= '0;
      load_discard  <= 1'b0;
      match_valid   <= 1'b0;
      consumed      <= '0;
      timeout_armed <= 1'b0;
      timeout_count <= '0;
      recomp_req    <= 1'b0;
      launch        <= 1'b0;
      inj_cnt       <= '0;
      col_cnt       <= '0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state) &&
                (state_next == S_FIRST || state_next == S_ADV || state_next == S_LONG);

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE_3270: mode_3270     <= cfg_data[0];
          CFG_MODE_NVT:  mode_nvt      <= cfg_data[0];
          CFG_TIMEOUT:   timeout_ticks <= cfg_data;
          default:       ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (recomp_req) begin
            inj_cnt    <= '0;
            col_cnt    <= '0;
          end else if (accept) begin
            case (kind)
              KIND_LOAD: begin
                if (load_discard) begin
                  if (s_tlast) load_discard <= 1'b0;
                end else if (!load_ok) begin
                  load_length  <= '0;
                  load_discard <= !s_tlast;
                end else if (s_tlast) begin
                  entry_count <= CW'(entry_count + CW'(1));
                  load_length <= '0;
                end else begin
                  load_length <= chk_len_of(load_length);
                end
              end
              KIND_KEY: begin
                // a key event cancels an armed timeout before matching
                timeout_armed <= 1'b0;
                timeout_count <= '0;
              end
              KIND_TICK: begin
                if (timeout_armed) begin
                  if (timeout_count > 16'd1) begin
                    timeout_count <= timeout_count - 16'd1;
                  end else begin
                    timeout_armed <= 1'b0;
                    timeout_count <= '0;
                    match_valid   <= 1'b0;
                    consumed      <= '0;
                  end
                end
              end
              default: begin
                entry_count   <= '0;
                load_length   <= '0;
                load_discard  <= 1'b0;
                match_valid   <= 1'b0;
                consumed      <= '0;
                timeout_armed <= 1'b0;
                timeout_count <= '0;
              end
            endcase
          end
        end
        S_FIRST: begin
          if (res_valid && res_have) begin
            match_valid <= 1'b1;
            consumed    <= '0;
          end
        end
        S_CHECK: begin
          if (chk_hit) consumed <= chk_next;
        end
        S_ADV: begin
          if (res_valid) begin
            if (res_have) begin
              consumed <= chk_next;
            end else begin
              match_valid <= 1'b0;
              consumed    <= '0;
            end
          end
        end
        S_LONG: begin
          if (res_valid) begin
            if (res_have) begin
              // ambiguous: wait for the timeout, keep matching the longer one
              timeout_armed <= 1'b1;
              timeout_count <= ticks_eff;
              match_valid   <= 1'b1;
            end else begin
              match_valid <= 1'b0;
              consumed    <= '0;
            end
          end
        end
        S_RECOMP: begin
          if (inj_cnt < CW'(N)) inj_cnt <= CW'(inj_cnt + CW'(1));
          if (res_valid) col_cnt <= CW'(col_cnt + CW'(1));
        end
        default: ;
      endcase

      // a request that arrives while a pass starts runs one more pass
      if (mode_wr || commit) begin
        recomp_req <= 1'b1;
      end else if (state == S_IDLE && recomp_req) begin
        recomp_req <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && kind == KIND_KEY) begin
      q_code <= in_code;
      q_st   <= in_mods;
    end

    if ((state == S_FIRST || state == S_ADV) && res_valid && res_have) begin
      cur_idx    <= ch_bidx[N];
      cur_codes  <= ch_bcodes[N];
      cur_hints  <= ch_bhints[N];
      cur_len    <= ch_blen[N];
      cur_action <= ch_bact[N];
    end
    if (state == S_LONG && res_valid && res_have) begin
      timeout_action <= cur_action;
      cur_idx        <= ch_bidx[N];
      cur_codes      <= ch_bcodes[N];
      cur_hints      <= ch_bhints[N];
      cur_len        <= ch_blen[N];
      cur_action     <= ch_bact[N];
    end

    case (state)
      S_IDLE: begin
        if (kind == KIND_LOAD) begin
          pend_status  <= STAT_REJECT;
          pend_action  <= '0;
          pend_compose <= match_valid;
        end else begin
          pend_status  <= STAT_ACTION;
          pend_action  <= timeout_action;
          pend_compose <= 1'b0;
        end
      end
      S_FIRST: begin
        pend_status  <= STAT_NONE;
        pend_action  <= '0;
        pend_compose <= 1'b0;
      end
      S_CHECK: begin
        pend_status  <= STAT_PENDING;
        pend_action  <= '0;
        pend_compose <= 1'b1;
      end
      S_ADV: begin
        pend_status  <= res_have ? STAT_PENDING : STAT_FAIL;
        pend_action  <= '0;
        pend_compose <= res_have;
      end
      S_LONG: begin
        pend_status  <= res_have ? STAT_PENDING : STAT_ACTION;
        pend_action  <= res_have ? 16'd0 : cur_action;
        pend_compose <= res_have;
      end
      default: begin
        pend_status  <= pend_status;
        pend_action  <= pend_action;
        pend_compose <= pend_compose;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_status  <= pend_status;
      out_action  <= pend_action;
      out_compose <= pend_compose;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {7'd0, out_compose, out_action};

  // a search record only leaves the chain while a scan is running
  assert property (@(posedge clk) disable iff (rst)
    ch_ctl[N].valid |-> (state == S_FIRST || state == S_ADV || state == S_LONG ||
                         state == S_RECOMP))
    else $error("chain result outside a scan");

  // an armed timeout always belongs to a pending ambiguous match
  assert property (@(posedge clk) disable iff (rst) timeout_armed |-> match_valid)
    else $error("timeout armed without pending match");

  assert property (@(posedge clk) disable iff (rst) entry_count <= CW'(N))
    else $error("entry count overflow");

endmodule
